>>> rtl/rsi_pkg.sv
`timescale 1ns / 1ps

package rsi_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int RADIUS_WIDTH    = 31;
   localparam int DIST_WIDTH      = 31;
   localparam int FRAC_BITS       = 16;
   localparam int NUM_COORDS      = 9;
   localparam int REQ_BITS        = NUM_COORDS * FIELD_WIDTH + RADIUS_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((DIST_WIDTH + 7) / 8) * 8;

   localparam int ORIGIN_X_LSB = 0 * FIELD_WIDTH;
   localparam int ORIGIN_Y_LSB = 1 * FIELD_WIDTH;
   localparam int ORIGIN_Z_LSB = 2 * FIELD_WIDTH;
   localparam int DIR_X_LSB    = 3 * FIELD_WIDTH;
   localparam int DIR_Y_LSB    = 4 * FIELD_WIDTH;
   localparam int DIR_Z_LSB    = 5 * FIELD_WIDTH;
   localparam int CENTER_X_LSB = 6 * FIELD_WIDTH;
   localparam int CENTER_Y_LSB = 7 * FIELD_WIDTH;
   localparam int CENTER_Z_LSB = 8 * FIELD_WIDTH;
   localparam int RADIUS_LSB   = 9 * FIELD_WIDTH;

   localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

endpackage

>>> rtl/ray_sphere_intersect.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports               Payload
// req      in   req_tvalid/tready   tdata: origin_x,y,z, dir_x,y,z, center_x,y,z, radius
// rsp      out  rsp_tvalid/tready   tuser: hit; tdata: hit_distance
//
// One transfer per cycle in and out; the depth is set by the square root
// pipeline, one result bit per stage.
// Reset clears only the valid bits; no state survives between items.
// A stalled output holds the whole pipeline unless the stage ahead of the
// output register is empty; bubbles in front of it are squeezed out.

module ray_sphere_intersect #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // center_x, center_y, center_z (32 each), radius (31), zero pad
   input  logic [rsi_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit_distance (31), zero pad
   output logic [rsi_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // hit
   output logic                                 rsp_tuser
);

   import rsi_pkg::*;

   localparam int EW       = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
   localparam int LW       = EW + 1;
   localparam int PW       = LW + EW;
   localparam int SQLW     = 2 * LW;
   localparam int DOTW     = PW + 2;
   localparam int BW       = DOTW - FRAC_BITS;
   localparam int MW       = BW;
   localparam int HW       = (MW + 1) / 2;
   localparam int HIW      = MW - HW;
   localparam int BBW      = 2 * MW;
   localparam int LLW      = SQLW + 2;
   localparam int RRW      = 2 * RADIUS_WIDTH;
   localparam int QW       = ((LLW > RRW) ? LLW : RRW) + 1;
   localparam int DMAX     = (BBW > QW) ? BBW : QW;
   localparam int DISCW0   = DMAX + 1;
   localparam int DISCW    = DISCW0 + (DISCW0 % 2);
   localparam int SQ_WIDTH = DISCW / 2;
   localparam int RW       = SQ_WIDTH + 2;
   localparam int TW       = ((BW > SQ_WIDTH) ? BW : SQ_WIDTH) + 2;

   logic out_en;
   logic pipe_en;

   // stage 1: offset from center
   logic signed [EW-1:0] ox, oy, oz, cx, cy, cz, dx, dy, dz;
   logic signed [LW-1:0] lx_in, ly_in, lz_in;
   logic signed [LW-1:0] lx_ff, ly_ff, lz_ff;
   logic signed [EW-1:0] dx_ff, dy_ff, dz_ff;
   logic [RADIUS_WIDTH-1:0] r1_ff;
   logic vld1_ff;

   assign ox = req_tdata[ORIGIN_X_LSB +: EW];
   assign oy = req_tdata[ORIGIN_Y_LSB +: EW];
   assign oz = req_tdata[ORIGIN_Z_LSB +: EW];
   assign dx = req_tdata[DIR_X_LSB +: EW];
   assign dy = req_tdata[DIR_Y_LSB +: EW];
   assign dz = req_tdata[DIR_Z_LSB +: EW];
   assign cx = req_tdata[CENTER_X_LSB +: EW];
   assign cy = req_tdata[CENTER_Y_LSB +: EW];
   assign cz = req_tdata[CENTER_Z_LSB +: EW];

   assign lx_in = LW'(ox) - LW'(cx);
   assign ly_in = LW'(oy) - LW'(cy);
   assign lz_in = LW'(oz) - LW'(cz);

   // stage 2: products
   logic signed [PW-1:0]   pd_x_in, pd_y_in, pd_z_in, pd_x_ff, pd_y_ff, pd_z_ff;
   logic signed [SQLW-1:0] pl_x_in, pl_y_in, pl_z_in, pl_x_ff, pl_y_ff, pl_z_ff;
   logic [RRW-1:0]         rr_in, rr2_ff;
   logic vld2_ff;

   assign pd_x_in = lx_ff * dx_ff;
   assign pd_y_in = ly_ff * dy_ff;
   assign pd_z_in = lz_ff * dz_ff;
   assign pl_x_in = lx_ff * lx_ff;
   assign pl_y_in = ly_ff * ly_ff;
   assign pl_z_in = lz_ff * lz_ff;
   assign rr_in   = RRW'(r1_ff) * RRW'(r1_ff);

   // stage 3: sums, b
   logic signed [DOTW-1:0] dot_in;
   logic signed [BW-1:0]   b3_in, b3_ff;
   logic signed [LLW-1:0]  ll3_in, ll3_ff;
   logic [RRW-1:0]         rr3_ff;
   logic vld3_ff;

   assign dot_in = DOTW'(pd_x_ff) + DOTW'(pd_y_ff) + DOTW'(pd_z_ff);
   assign b3_in  = dot_in[DOTW-1:FRAC_BITS];
   assign ll3_in = LLW'(pl_x_ff) + LLW'(pl_y_ff) + LLW'(pl_z_ff);

   // stage 4: |b|, r*r - L.L
   logic [MW-1:0]        mag4_in, mag4_ff;
   logic signed [QW-1:0] q4_in, q4_ff;
   logic signed [BW-1:0] b4_ff;
   logic vld4_ff;

   assign mag4_in = b3_ff[BW-1] ? MW'(-b3_ff) : MW'(b3_ff);
   assign q4_in   = QW'(rr3_ff) - QW'(ll3_ff);

   // stage 5: partial products of b*b
   logic [2*HIW-1:0]     hh5_in, hh5_ff;
   logic [HIW+HW-1:0]    hl5_in, hl5_ff;
   logic [2*HW-1:0]      lo5_in, lo5_ff;
   logic signed [BW-1:0] b5_ff;
   logic signed [QW-1:0] q5_ff;
   logic vld5_ff;

   assign hh5_in = (2*HIW)'(mag4_ff[MW-1:HW]) * (2*HIW)'(mag4_ff[MW-1:HW]);
   assign hl5_in = (HIW+HW)'(mag4_ff[MW-1:HW]) * (HIW+HW)'(mag4_ff[HW-1:0]);
   assign lo5_in = (2*HW)'(mag4_ff[HW-1:0]) * (2*HW)'(mag4_ff[HW-1:0]);

   // stage 6: b*b
   logic [BBW-1:0]       bb6_in, bb6_ff;
   logic signed [BW-1:0] b6_ff;
   logic signed [QW-1:0] q6_ff;
   logic vld6_ff;

   assign bb6_in = (BBW'(hh5_ff) << (2 * HW)) + (BBW'(hl5_ff) << (HW + 1))
                 + BBW'(lo5_ff);

   // stage 7: discriminant, then the square root stages
   logic signed [DISCW-1:0] disc_in;
   assign disc_in = DISCW'(bb6_ff) + DISCW'(q6_ff);

   logic [SQ_WIDTH-1:0]  sq_root_ff [0:SQ_WIDTH];
   logic [RW-1:0]        sq_rem_ff  [0:SQ_WIDTH-1];
   logic [DISCW-1:0]     sq_rad_ff  [0:SQ_WIDTH-1];
   logic signed [BW-1:0] sq_b_ff    [0:SQ_WIDTH];
   logic                 sq_neg_ff  [0:SQ_WIDTH];
   logic                 sq_vld_ff  [0:SQ_WIDTH];

   // final stages
   logic signed [TW-1:0] nb, t1_in, t2_in, t1_ff, t2_ff, t_sel;
   logic neg_f_ff;
   logic vld_f_ff;
   logic hit_in;
   logic [DIST_WIDTH-1:0] dist_in;
   logic [DIST_WIDTH-1:0] dist_ff;
   logic hit_ff;
   logic rsp_vld_ff;

   assign out_en     = !rsp_vld_ff || rsp_tready;
   assign pipe_en    = out_en || !vld_f_ff;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         vld1_ff <= req_tvalid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         sq_vld_ff[0] <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         lz_ff   <= lz_in;
         dx_ff   <= dx;
         dy_ff   <= dy;
         dz_ff   <= dz;
         r1_ff   <= req_tdata[RADIUS_LSB +: RADIUS_WIDTH];

         pd_x_ff <= pd_x_in;
         pd_y_ff <= pd_y_in;
         pd_z_ff <= pd_z_in;
         pl_x_ff <= pl_x_in;
         pl_y_ff <= pl_y_in;
         pl_z_ff <= pl_z_in;
         rr2_ff  <= rr_in;

         b3_ff   <= b3_in;
         ll3_ff  <= ll3_in;
         rr3_ff  <= rr2_ff;

         mag4_ff <= mag4_in;
         q4_ff   <= q4_in;
         b4_ff   <= b3_ff;

         hh5_ff  <= hh5_in;
         hl5_ff  <= hl5_in;
         lo5_ff  <= lo5_in;
         b5_ff   <= b4_ff;
         q5_ff   <= q4_ff;

         bb6_ff  <= bb6_in;
         b6_ff   <= b5_ff;
         q6_ff   <= q5_ff;

         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
         sq_rad_ff[0]  <= disc_in;
         sq_b_ff[0]    <= b6_ff;
         sq_neg_ff[0]  <= disc_in[DISCW-1];
      end
   end

   // restoring square root, one root bit per stage
   genvar k;
   generate
      for (k = 0; k < SQ_WIDTH; k++) begin : g_sqrt
         logic [RW-1:0] rem_sh;
         logic [RW-1:0] trial;
         logic          ge;

         assign rem_sh = {sq_rem_ff[k][RW-3:0], sq_rad_ff[k][DISCW-1 -: 2]};
         assign trial  = {sq_root_ff[k], 2'b01};
         assign ge     = rem_sh >= trial;

         always_ff @(posedge clock) begin
            if (reset) begin
               sq_vld_ff[k+1] <= 1'b0;
            end else if (pipe_en) begin
               sq_vld_ff[k+1] <= sq_vld_ff[k];
            end
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               sq_root_ff[k+1] <= {sq_root_ff[k][SQ_WIDTH-2:0], ge};
               sq_b_ff[k+1]    <= sq_b_ff[k];
               sq_neg_ff[k+1]  <= sq_neg_ff[k];
            end
         end

         if (k < SQ_WIDTH - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (pipe_en) begin
                  sq_rem_ff[k+1] <= ge ? rem_sh - trial : rem_sh;
                  sq_rad_ff[k+1] <= {sq_rad_ff[k][DISCW-3:0], 2'b00};
               end
            end
         end
      end
   endgenerate

   // both roots
   assign nb    = -TW'(sq_b_ff[SQ_WIDTH]);
   assign t1_in = nb - TW'(sq_root_ff[SQ_WIDTH]);
   assign t2_in = nb + TW'(sq_root_ff[SQ_WIDTH]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_f_ff <= sq_vld_ff[SQ_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         neg_f_ff <= sq_neg_ff[SQ_WIDTH];
      end
   end

   // root select, saturation
   always_comb begin
      t_sel  = t1_ff[TW-1] ? t2_ff : t1_ff;
      hit_in = !neg_f_ff && !t_sel[TW-1];
      if (!hit_in) begin
         dist_in = '0;
      end else if (|t_sel[TW-2:DIST_WIDTH]) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = t_sel[DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_en) begin
         rsp_vld_ff <= vld_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(dist_ff);

endmodule
